// ----- src/assert_macros.svh -----
// assertion helpers for the arc point generator checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define APG_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define APG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/apg_pkg.sv -----
// ----------------------------------------------------------------------------
// apg_pkg
// Shared types, constants and tables for the arc point generator.
// ----------------------------------------------------------------------------
package apg_pkg;

  localparam int MAX_POINTS               = 64;
  localparam int ANGLE_FRACTION_BITS_DEF  = 16;
  localparam int STEP_EXTRA_BITS          = 16;
  localparam int HORNER_N                 = 11;
  localparam int COS_LAST                 = 5;
  localparam logic [26:0] DEG_TO_RAD_Q32  = 27'd74961321;

  // datapath operations
  localparam logic [4:0] OP_NONE     = 5'd0;
  localparam logic [4:0] OP_LOAD     = 5'd1;
  localparam logic [4:0] OP_DIV_INIT = 5'd2;
  localparam logic [4:0] OP_DIV_STEP = 5'd3;
  localparam logic [4:0] OP_OCT_INIT = 5'd4;
  localparam logic [4:0] OP_OCT_STEP = 5'd5;
  localparam logic [4:0] OP_FOLD     = 5'd6;
  localparam logic [4:0] OP_MUL_XLO  = 5'd7;
  localparam logic [4:0] OP_SET_X    = 5'd8;
  localparam logic [4:0] OP_MUL_XX   = 5'd9;
  localparam logic [4:0] OP_SET_X2   = 5'd10;
  localparam logic [4:0] OP_HMUL     = 5'd11;
  localparam logic [4:0] OP_HREC     = 5'd12;
  localparam logic [4:0] OP_HCOR     = 5'd13;
  localparam logic [4:0] OP_MUL_S    = 5'd14;
  localparam logic [4:0] OP_SET_S    = 5'd15;
  localparam logic [4:0] OP_MUL_PX   = 5'd16;
  localparam logic [4:0] OP_SET_PX   = 5'd17;
  localparam logic [4:0] OP_MUL_PY   = 5'd18;
  localparam logic [4:0] OP_SET_PY   = 5'd19;
  localparam logic [4:0] OP_EMIT     = 5'd20;
  localparam logic [4:0] OP_EMIT_BAD = 5'd21;

  typedef struct packed {
    logic [4:0] op;
    logic [3:0] sel;
  } apg_cmd_t;

  typedef struct packed {
    logic bad;
    logic last_pt;
    logic out_free;
  } apg_status_t;

  // step divider length: dividend is angle << 16 or 360 << phase bits
  function automatic int div_w(input int afb);
    return (41 > 25 + afb) ? 41 : 25 + afb;
  endfunction

  // horner divisors, cosine terms then sine terms
  function automatic logic [7:0] horner_div(input logic [3:0] k);
    case (k)
      4'd0:    return 8'd132;
      4'd1:    return 8'd90;
      4'd2:    return 8'd56;
      4'd3:    return 8'd30;
      4'd4:    return 8'd12;
      4'd5:    return 8'd2;
      4'd6:    return 8'd110;
      4'd7:    return 8'd72;
      4'd8:    return 8'd42;
      4'd9:    return 8'd20;
      4'd10:   return 8'd6;
      default: return 8'd1;
    endcase
  endfunction

  // floor(2^32 / divisor)
  function automatic logic [31:0] horner_rcp(input logic [3:0] k);
    case (k)
      4'd0:    return 32'd32537631;
      4'd1:    return 32'd47721858;
      4'd2:    return 32'd76695844;
      4'd3:    return 32'd143165576;
      4'd4:    return 32'd357913941;
      4'd5:    return 32'd2147483648;
      4'd6:    return 32'd39045157;
      4'd7:    return 32'd59652323;
      4'd8:    return 32'd102261126;
      4'd9:    return 32'd214748364;
      4'd10:   return 32'd715827882;
      default: return 32'hFFFFFFFF;
    endcase
  endfunction

endpackage

// ----- src/arc_point_generator.sv -----
// ----------------------------------------------------------------------------
// arc_point_generator
// Points on a circular arc about the origin, signed Q15.16, one run per request.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | radius, sweep_angle, point_count
//  out     | output    | out_valid/out_stall| point_x/y, point_index, last, bad_request
//  cfg     | input     | cfg_we             | cfg_wdata (compare tolerance)
//
// a good request runs the check, the step division (DIVW = 41 at 16 fraction
// bits) and one pass per point through the one shared 33x33 multiplier (11
// horner terms); the step divider gives one quotient bit per cycle
// a rejected request gives its flagged result once the output is free
// synchronous reset clears the sequencer and the output valid, tolerance goes to 1
// a stalled result holds; the next point is prepared behind it
// ----------------------------------------------------------------------------
module arc_point_generator #(
  parameter int ANGLE_FRACTION_BITS = apg_pkg::ANGLE_FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [30:0]        in_radius,
  input  logic [24:0]        in_sweep_angle,
  input  logic [7:0]         in_point_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic [5:0]         out_point_index,
  output logic               out_last,
  output logic               out_bad_request
);
  import apg_pkg::*;

  apg_cmd_t    cmd;
  apg_status_t status;

  apg_ctrl #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  apg_dp #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_radius       (in_radius),
    .in_sweep_angle  (in_sweep_angle),
    .in_point_count  (in_point_count),
    .out_stall       (out_stall),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_point_index (out_point_index),
    .out_last        (out_last),
    .out_bad_request (out_bad_request)
  );

endmodule

// ----- src/apg_ctrl.sv -----
// ----------------------------------------------------------------------------
// apg_ctrl
// Sequencer: check, step division, then the per-point operation sequence.
// ----------------------------------------------------------------------------
module apg_ctrl #(
  parameter int ANGLE_FRACTION_BITS = apg_pkg::ANGLE_FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  apg_pkg::apg_status_t status,
  output apg_pkg::apg_cmd_t    cmd
);
  import apg_pkg::*;

  localparam int DIVW  = div_w(ANGLE_FRACTION_BITS);
  localparam int CNT_W = $clog2(DIVW);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIVW - 1);
  localparam logic [CNT_W-1:0] PRE_LAST  = CNT_W'(8);
  localparam logic [CNT_W-1:0] POST_LAST = CNT_W'(5);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_PRE   = 3'd3;
  localparam logic [2:0] S_HORN  = 3'd4;
  localparam logic [2:0] S_POST  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;
  localparam logic [2:0] S_BAD   = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]       k_r, k_nxt;
  logic [1:0]       h_r, h_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    h_nxt     = h_r;
    cmd.op    = OP_NONE;
    cmd.sel   = 4'd0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.bad) begin
          state_nxt = S_BAD;
        end else begin
          cmd.op    = OP_DIV_INIT;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_PRE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_PRE: begin
        case (cnt_r)
          CNT_W'(0): cmd.op = OP_OCT_INIT;
          CNT_W'(1): begin cmd.op = OP_OCT_STEP; cmd.sel = 4'd2; end
          CNT_W'(2): begin cmd.op = OP_OCT_STEP; cmd.sel = 4'd1; end
          CNT_W'(3): begin cmd.op = OP_OCT_STEP; cmd.sel = 4'd0; end
          CNT_W'(4): cmd.op = OP_FOLD;
          CNT_W'(5): cmd.op = OP_MUL_XLO;
          CNT_W'(6): cmd.op = OP_SET_X;
          CNT_W'(7): cmd.op = OP_MUL_XX;
          default:   cmd.op = OP_SET_X2;
        endcase
        if (cnt_r == PRE_LAST) begin
          k_nxt     = 4'd0;
          h_nxt     = 2'd0;
          state_nxt = S_HORN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_HORN: begin
        cmd.sel = k_r;
        case (h_r)
          2'd0:    cmd.op = OP_HMUL;
          2'd1:    cmd.op = OP_HREC;
          default: cmd.op = OP_HCOR;
        endcase
        if (h_r == 2'd2) begin
          h_nxt = 2'd0;
          if (k_r == 4'(HORNER_N - 1)) begin
            cnt_nxt   = '0;
            state_nxt = S_POST;
          end else begin
            k_nxt = k_r + 4'd1;
          end
        end else begin
          h_nxt = h_r + 2'd1;
        end
      end
      S_POST: begin
        case (cnt_r)
          CNT_W'(0): cmd.op = OP_MUL_S;
          CNT_W'(1): cmd.op = OP_SET_S;
          CNT_W'(2): cmd.op = OP_MUL_PX;
          CNT_W'(3): cmd.op = OP_SET_PX;
          CNT_W'(4): cmd.op = OP_MUL_PY;
          default:   cmd.op = OP_SET_PY;
        endcase
        if (cnt_r == POST_LAST) begin
          state_nxt = S_EMIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.op  = OP_EMIT;
          cnt_nxt = '0;
          state_nxt = status.last_pt ? S_IDLE : S_PRE;
        end
      end
      S_BAD: begin
        if (status.out_free) begin
          cmd.op    = OP_EMIT_BAD;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      k_r     <= 4'd0;
      h_r     <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      h_r     <= h_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ----- src/apg_dp.sv -----
// ----------------------------------------------------------------------------
// apg_dp
// Datapath: request checks, step divider, octant fold, shared multiplier,
// horner evaluation, coordinate scaling and the output register.
// ----------------------------------------------------------------------------
module apg_dp #(
  parameter int ANGLE_FRACTION_BITS = apg_pkg::ANGLE_FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata,
  input  logic [30:0]          in_radius,
  input  logic [24:0]          in_sweep_angle,
  input  logic [7:0]           in_point_count,
  input  logic                 out_stall,
  input  apg_pkg::apg_cmd_t    cmd,
  output apg_pkg::apg_status_t status,
  output logic                 out_valid,
  output logic signed [31:0]   out_point_x,
  output logic signed [31:0]   out_point_y,
  output logic [5:0]           out_point_index,
  output logic                 out_last,
  output logic                 out_bad_request
);
  import apg_pkg::*;

  localparam int PB    = ANGLE_FRACTION_BITS + STEP_EXTRA_BITS;
  localparam int PH_W  = PB + 9;
  localparam int OCT_W = PB + 6;
  localparam int DIVW  = div_w(ANGLE_FRACTION_BITS);
  localparam int CMP_W = (ANGLE_FRACTION_BITS + 10 > 26) ? ANGLE_FRACTION_BITS + 10 : 26;
  localparam int SH_R  = (PB >= 32) ? PB - 32 : 0;
  localparam int SH_L  = (PB < 32) ? 32 - PB : 0;

  localparam logic [CMP_W-1:0] FULL_DEG = CMP_W'(360) << ANGLE_FRACTION_BITS;
  localparam logic [PH_W-1:0]  FULL_PH  = PH_W'(360) << PB;
  localparam logic [PH_W-1:0]  OCT_PH   = PH_W'(45) << PB;
  localparam logic [OCT_W-1:0] OCT_R    = OCT_W'(45) << PB;
  localparam logic [DIVW-1:0]  DIV_FULL = DIVW'(360) << PB;
  localparam logic [32:0]      UNIT     = 33'h1_0000_0000;

  logic [15:0]       tol_r;
  logic [30:0]       radius_r;
  logic [24:0]       angle_r;
  logic [7:0]        n_r;
  logic [6:0]        rem_r, den_r;
  logic [DIVW-1:0]   quo_r;
  logic [PH_W-1:0]   phase_r, r_r;
  logic [5:0]        idx_r;
  logic [2:0]        q_r;
  logic [37:0]       r32_r;
  logic [32:0]       hi_r, t_r, c_r, s_r;
  logic [31:0]       x_r, x2_r, p_r, px_r, py_r;
  logic [63:0]       prod_r;
  logic              out_valid_r;

  // checks
  logic [CMP_W-1:0] ang, tolw;
  logic             bad, full;

  assign ang  = CMP_W'(angle_r);
  assign tolw = CMP_W'(tol_r);
  assign bad  = (radius_r <= 31'(tol_r)) || (ang <= tolw) || (ang > FULL_DEG + tolw)
                || (n_r < 8'd2) || (n_r > 8'(MAX_POINTS));
  assign full = (ang + tolw >= FULL_DEG);

  // step divider, one quotient bit per cycle
  logic [7:0] div_rs;
  logic       div_bit;
  logic [6:0] rem_nxt;

  always_comb begin
    div_rs  = {rem_r, quo_r[DIVW-1]};
    div_bit = (div_rs >= {1'b0, den_r});
    rem_nxt = div_bit ? 7'(div_rs - {1'b0, den_r}) : div_rs[6:0];
  end

  // phase advance, the step is always below a full turn
  logic [PH_W:0]   psum;
  logic [PH_W-1:0] phase_nxt;

  always_comb begin
    psum = {1'b0, phase_r} + {1'b0, quo_r[PH_W-1:0]};
    if (psum >= {1'b0, FULL_PH}) begin
      psum = psum - {1'b0, FULL_PH};
    end
    phase_nxt = psum[PH_W-1:0];
  end

  // octant steps and fold
  logic [PH_W-1:0]  oct_cmp;
  logic [OCT_W-1:0] rf;
  logic [37:0]      r32_nxt;

  always_comb begin
    oct_cmp = OCT_PH << cmd.sel[1:0];
    rf      = q_r[0] ? OCT_R - r_r[OCT_W-1:0] : r_r[OCT_W-1:0];
    if (PB >= 32) begin
      r32_nxt = 38'(rf >> SH_R);
    end else begin
      r32_nxt = 38'(rf) << SH_L;
    end
  end

  // octant symmetry
  logic        use_c, cn, sn;
  logic [32:0] cm, sm;

  assign use_c = ~(q_r[1] ^ q_r[0]);
  assign cm    = use_c ? c_r : s_r;
  assign sm    = use_c ? s_r : c_r;
  assign cn    = q_r[2] ^ q_r[1];
  assign sn    = q_r[2];

  // shared multiplier
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_full;

  always_comb begin
    mul_a = 33'd0;
    mul_b = 33'd0;
    case (cmd.op)
      OP_MUL_XLO: begin mul_a = {1'b0, r32_r[31:0]}; mul_b = 33'(DEG_TO_RAD_Q32); end
      OP_MUL_XX:  begin mul_a = {1'b0, x_r};  mul_b = {1'b0, x_r}; end
      OP_HMUL:    begin mul_a = {1'b0, x2_r}; mul_b = t_r; end
      OP_HREC:    begin mul_a = {1'b0, prod_r[63:32]}; mul_b = {1'b0, horner_rcp(cmd.sel)}; end
      OP_MUL_S:   begin mul_a = {1'b0, x_r};  mul_b = t_r; end
      OP_MUL_PX:  begin mul_a = {2'b0, radius_r}; mul_b = cm; end
      OP_MUL_PY:  begin mul_a = {2'b0, radius_r}; mul_b = sm; end
      default:    begin mul_a = 33'd0; mul_b = 33'd0; end
    endcase
    mul_full = {33'd0, mul_a} * {33'd0, mul_b};
  end

  // reciprocal estimate is exact or one low
  logic [7:0]  hd;
  logic [39:0] qd, hrem;
  logic [32:0] qc, t_nxt;

  always_comb begin
    hd    = horner_div(cmd.sel);
    qd    = {8'd0, prod_r[63:32]} * {32'd0, hd};
    hrem  = {8'd0, p_r} - qd;
    qc    = (hrem >= {32'd0, hd}) ? {1'b0, prod_r[63:32]} + 33'd1 : {1'b0, prod_r[63:32]};
    t_nxt = UNIT - qc;
  end

  function automatic logic [31:0] scale(input logic [63:0] pr, input logic neg);
    logic [64:0] sum;
    logic [32:0] mag;
    sum = {1'b0, pr} + 65'h8000_0000;
    mag = sum[64:32];
    if (mag > 33'h7FFF_FFFF) begin
      mag = 33'h7FFF_FFFF;
    end
    return neg ? 32'(33'd0 - mag) : mag[31:0];
  endfunction

  logic last_pt;
  assign last_pt = ({2'b0, idx_r} == n_r - 8'd1);

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        radius_r <= in_radius;
        angle_r  <= in_sweep_angle;
        n_r      <= in_point_count;
      end
      OP_DIV_INIT: begin
        quo_r   <= full ? DIV_FULL : DIVW'(angle_r) << STEP_EXTRA_BITS;
        rem_r   <= 7'd0;
        den_r   <= full ? n_r[6:0] : 7'(n_r - 8'd1);
        phase_r <= '0;
        idx_r   <= 6'd0;
      end
      OP_DIV_STEP: begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[DIVW-2:0], div_bit};
      end
      OP_OCT_INIT: begin
        r_r <= phase_r;
        q_r <= 3'd0;
      end
      OP_OCT_STEP: begin
        if (r_r >= oct_cmp) begin
          r_r <= r_r - oct_cmp;
          q_r[cmd.sel[1:0]] <= 1'b1;
        end
      end
      OP_FOLD:    r32_r <= r32_nxt;
      OP_MUL_XLO: begin
        prod_r <= mul_full[63:0];
        hi_r   <= {27'd0, r32_r[37:32]} * 33'(DEG_TO_RAD_Q32);
      end
      OP_SET_X:   x_r <= 32'(hi_r + {1'b0, prod_r[63:32]});
      OP_SET_X2: begin
        x2_r <= prod_r[63:32];
        t_r  <= UNIT;
      end
      OP_HREC: begin
        p_r    <= prod_r[63:32];
        prod_r <= mul_full[63:0];
      end
      OP_HCOR: begin
        if (cmd.sel == 4'(COS_LAST)) begin
          c_r <= t_nxt;
          t_r <= UNIT;
        end else begin
          t_r <= t_nxt;
        end
      end
      OP_MUL_XX, OP_HMUL, OP_MUL_S, OP_MUL_PX, OP_MUL_PY: prod_r <= mul_full[63:0];
      OP_SET_S:  s_r  <= {1'b0, prod_r[63:32]};
      OP_SET_PX: px_r <= scale(prod_r, cn);
      OP_SET_PY: py_r <= scale(prod_r, sn);
      OP_EMIT: begin
        out_point_x     <= px_r;
        out_point_y     <= py_r;
        out_point_index <= idx_r;
        out_last        <= last_pt;
        out_bad_request <= 1'b0;
        phase_r         <= phase_nxt;
        idx_r           <= idx_r + 6'd1;
      end
      OP_EMIT_BAD: begin
        out_point_x     <= 32'sd0;
        out_point_y     <= 32'sd0;
        out_point_index <= 6'd0;
        out_last        <= 1'b1;
        out_bad_request <= 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r       <= 16'd1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
      if (cmd.op == OP_EMIT || cmd.op == OP_EMIT_BAD) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign status.bad      = bad;
  assign status.last_pt  = last_pt;
  assign status.out_free = !out_valid_r || !out_stall;

endmodule

// ----- src/apg_checker.sv -----
// ----------------------------------------------------------------------------
// apg_checker
// Port-level checks on the arc point generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module apg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_point_x,
  input logic [31:0] out_point_y,
  input logic [5:0]  out_point_index,
  input logic        out_last,
  input logic        out_bad_request
);

  // a stalled result holds
  `APG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_point_x) && $stable(out_point_y) && $stable(out_point_index) && $stable(out_last), "stalled result changed")

  // a rejected request is one zeroed result that closes the run
  `APG_ASSERT(a_bad_shape, out_valid && out_bad_request, out_last && out_point_x == 32'd0 && out_point_y == 32'd0 && out_point_index == 6'd0, "bad request result malformed")

  // one request at a time
  `APG_ASSERT_NEXT(a_in_busy, in_valid && !in_stall, in_stall, "request taken while busy")

  // a run starts at the positive x axis with index zero
  `APG_ASSERT(a_first_pt, out_valid && !out_bad_request && out_point_index == 6'd0, out_point_y == 32'd0 && !out_point_x[31], "first point off the x axis")

endmodule

bind arc_point_generator apg_checker u_apg_checker (.*);

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the arc point generator. Requests go in from a
// queue, results are compared field by field with a bit-exact fixed point
// prediction of each run, over several compare tolerance settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          WATCHDOG_LIMIT = 20000;
  localparam logic [63:0] FULL_DEG       = 64'd360 << 16;
  localparam logic [63:0] FULL_PHASE     = 64'd360 << 32;
  localparam logic [63:0] OCT_PHASE      = 64'd45 << 32;
  localparam logic [63:0] UNIT           = 64'd1 << 32;
  localparam logic [63:0] RAD_PER_DEG    = 64'd74961321;

  typedef struct packed {
    logic [30:0] radius;
    logic [24:0] sweep;
    logic [7:0]  count;
  } arc_request_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [5:0]  index;
    logic        last;
    logic        bad;
  } arc_point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [30:0] in_radius = '0;
  logic [24:0] in_sweep_angle = '0;
  logic [7:0] in_point_count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_point_x, out_point_y;
  logic [5:0] out_point_index;
  logic out_last, out_bad_request;

  arc_request_t pending_requests[$];
  arc_point_t   expected_points[$];
  logic [15:0]  tolerance = 16'd1;
  int  mismatches = 0;
  int  idle_cycles = 0;
  int  send_gap = 0;
  int  stall_burst = 0;
  int  hold_cycles = 0;
  bit  quiet = 1'b0;
  logic in_took = 1'b0;

  arc_point_generator uut (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .in_valid, .in_stall, .in_radius, .in_sweep_angle, .in_point_count,
    .out_valid, .out_stall, .out_point_x, .out_point_y, .out_point_index,
    .out_last, .out_bad_request
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] horner_eval(input logic [63:0] x2, input bit is_cos);
    logic [63:0] t;
    int cos_d[6];
    int sin_d[5];
    cos_d = '{132, 90, 56, 30, 12, 2};
    sin_d = '{110, 72, 42, 20, 6};
    t = UNIT;
    if (is_cos) begin
      for (int k = 0; k < 6; k++) t = UNIT - (((x2 * t) >> 32) / cos_d[k]);
    end else begin
      for (int k = 0; k < 5; k++) t = UNIT - (((x2 * t) >> 32) / sin_d[k]);
    end
    return t;
  endfunction

  function automatic logic [31:0] scaled_coord(input logic [63:0] radius,
                                               input logic [63:0] mag, input bit neg);
    logic [63:0] p;
    p = (radius * mag + (64'd1 << 31)) >> 32;
    if (p > 64'h7FFF_FFFF) p = 64'h7FFF_FFFF;
    return neg ? (32'd0 - p[31:0]) : p[31:0];
  endfunction

  // expected points of one request, appended to the expected queue
  task automatic predict_arc(input arc_request_t rq);
    logic [63:0] r, a, n, step, ph, oct, rem, x, x2, c, s, cm, sm;
    bit cn, sn;
    arc_point_t pt;
    r = rq.radius;
    a = rq.sweep;
    n = rq.count;
    if (r <= tolerance || a <= tolerance || a > FULL_DEG + tolerance ||
        n < 2 || n > apg_pkg::MAX_POINTS) begin
      pt = '{x: '0, y: '0, index: '0, last: 1'b1, bad: 1'b1};
      expected_points.push_back(pt);
      return;
    end
    if (a + tolerance >= FULL_DEG) step = (FULL_DEG << 16) / n;
    else step = (a << 16) / (n - 1);
    for (logic [63:0] i = 0; i < n; i++) begin
      ph = (i * step) % FULL_PHASE;
      oct = ph / OCT_PHASE;
      rem = ph - oct * OCT_PHASE;
      if (oct[0]) rem = OCT_PHASE - rem;
      x = (rem >> 32) * RAD_PER_DEG + (((rem & 64'hFFFF_FFFF) * RAD_PER_DEG) >> 32);
      x2 = (x * x) >> 32;
      c = horner_eval(x2, 1'b1);
      s = (x * horner_eval(x2, 1'b0)) >> 32;
      // octant symmetry: octants 1, 2, 5 and 6 swap sine and cosine
      cm = (oct[1] ^ oct[0]) ? s : c;
      sm = (oct[1] ^ oct[0]) ? c : s;
      cn = (oct[2:0] >= 2 && oct[2:0] <= 5);
      sn = oct[2];
      pt.x = scaled_coord(r, cm, cn);
      pt.y = scaled_coord(r, sm, sn);
      pt.index = i[5:0];
      pt.last = (i == n - 1);
      pt.bad = 1'b0;
      expected_points.push_back(pt);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // predictor, monitor and watchdog
  always @(posedge clk) begin
    arc_request_t rq;
    arc_point_t want;
    bit moved;
    moved = 1'b0;
    in_took <= in_valid && !in_stall && rst_n;
    if (rst_n) begin
      if (cfg_we) tolerance = cfg_wdata;
      if (in_valid && !in_stall) begin
        rq = '{radius: in_radius, sweep: in_sweep_angle, count: in_point_count};
        predict_arc(rq);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_point_index), 32'd0);
        end else begin
          want = expected_points.pop_front();
          if (out_point_x !== want.x) report_mismatch("point_x", out_point_x, want.x);
          if (out_point_y !== want.y) report_mismatch("point_y", out_point_y, want.y);
          if (out_point_index !== want.index)
            report_mismatch("point_index", 32'(out_point_index), 32'(want.index));
          if (out_last !== want.last)
            report_mismatch("last", 32'(out_last), 32'(want.last));
          if (out_bad_request !== want.bad)
            report_mismatch("bad_request", 32'(out_bad_request), 32'(want.bad));
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("arc_point_generator verification failed");
        $finish;
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    arc_request_t rq;
    if (rst_n && (!in_valid || in_took)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (pending_requests.size() > 0) begin
        rq = pending_requests.pop_front();
        in_radius <= rq.radius;
        in_sweep_angle <= rq.sweep;
        in_point_count <= rq.count;
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(3) == 0) send_gap = $urandom_range(1, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall, random bursts and one long hold
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else if (stall_burst > 0) begin
      out_stall <= 1'b1;
      stall_burst--;
    end else if (!quiet && $urandom_range(4) == 0) begin
      out_stall <= 1'b1;
      stall_burst = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic add_request(input logic [30:0] r, input logic [24:0] a,
                             input logic [7:0] n);
    arc_request_t rq;
    rq = '{radius: r, sweep: a, count: n};
    pending_requests.push_back(rq);
  endtask

  task automatic wait_drained();
    while (pending_requests.size() > 0 || in_valid || expected_points.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_random_requests(input int count);
    logic [31:0] r, a, n;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(9) < 8) begin
        r = $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0100_0000, 2);
        case ($urandom_range(3))
          0: a = 32'(FULL_DEG);
          1: a = 32'(FULL_DEG - tolerance + $urandom_range(2 * tolerance));
          default: a = $urandom_range(32'(FULL_DEG - 1), 32'(tolerance + 1));
        endcase
        n = $urandom_range(19) == 0 ? $urandom_range(apg_pkg::MAX_POINTS, 9)
                                    : $urandom_range(8, 2);
      end else begin
        r = $urandom;
        a = $urandom;
        n = $urandom;
      end
      add_request(r[30:0], a[24:0], n[7:0]);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // limits of the checks at the reset tolerance of one
    add_request(31'd0, FULL_DEG[24:0], 8'd4);
    add_request(31'd1, FULL_DEG[24:0], 8'd4);
    add_request(31'd2, FULL_DEG[24:0], 8'd4);
    add_request(31'h7FFF_FFFF, 25'd90 << 16, 8'd2);
    add_request(31'h0001_0000, 25'd0, 8'd3);
    add_request(31'h0001_0000, 25'd1, 8'd3);
    add_request(31'h0001_0000, 25'd2, 8'd3);
    add_request(31'h0001_0000, FULL_DEG[24:0] + 25'd1, 8'd8);
    add_request(31'h0001_0000, FULL_DEG[24:0] + 25'd2, 8'd8);
    add_request(31'h0001_0000, FULL_DEG[24:0] - 25'd1, 8'd8);
    add_request(31'h0001_0000, FULL_DEG[24:0] - 25'd2, 8'd8);
    add_request(31'h0001_0000, 25'h1FF_FFFF, 8'd8);
    add_request(31'h0001_0000, 25'd180 << 16, 8'd0);
    add_request(31'h0001_0000, 25'd180 << 16, 8'd1);
    add_request(31'h7FFF_FFFF, FULL_DEG[24:0], 8'd64);
    add_request(31'h0001_0000, 25'd270 << 16, 8'd65);
    add_request(31'h0001_0000, 25'd270 << 16, 8'd255);
    add_request(31'h0123_4567, 25'd315 << 16, 8'd8);
    wait_drained();

    // long output hold while requests keep coming
    add_random_requests(10);
    @(posedge clk);
    hold_cycles = 400;
    wait_drained();

    write_tolerance(16'd0);
    add_request(31'd1, 25'd1, 8'd2);
    add_request(31'd0, 25'd1, 8'd2);
    add_request(31'd5, FULL_DEG[24:0] - 25'd1, 8'd5);
    add_random_requests(50);
    wait_drained();

    write_tolerance(16'hFFFF);
    add_request(31'h0000_FFFF, FULL_DEG[24:0], 8'd4);
    add_request(31'h0001_0000, 25'h0_FFFF, 8'd4);
    add_request(31'h0001_0000, 25'h1_0000, 8'd4);
    add_request(31'h0001_0000, FULL_DEG[24:0] + 25'hFFFF, 8'd6);
    add_request(31'h0001_0000, FULL_DEG[24:0] + 25'h1_0000, 8'd6);
    add_random_requests(50);
    wait_drained();

    write_tolerance(16'($urandom_range(16'hFFFF)));
    add_random_requests(50);
    wait_drained();

    write_tolerance(16'd1);
    add_random_requests(35);
    wait_drained();

    quiet = 1'b1;
    add_random_requests(25);
    wait_drained();
    repeat (20) @(posedge clk);

    if (expected_points.size() != 0)
      report_mismatch("results still expected", 32'(expected_points.size()), 32'd0);
    if (mismatches == 0) begin
      $display("arc_point_generator verification clean");
    end else begin
      $display("arc_point_generator verification failed");
    end
    $finish;
  end

endmodule
